>>> rtl/lmfc_pkg.sv
// Shared types and constants for the move-to-front LRU cache.
package lmfc_pkg;

    localparam int KEY_W         = 31;
    localparam int HANDLE_W      = 32;
    localparam int ENTRIES_DEF   = 8;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_FILL   = 1'b1;

    typedef struct packed {
        logic                valid;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } slot_t;

    typedef struct packed {
        logic capture;  // latch key compare for the transaction being accepted
        logic shift;    // update pass: take neighbor slot unless a match sits ahead
    } cell_ctrl_t;

endpackage

>>> rtl/lru_move_to_front_cache_core.sv
// Top level of the fully associative move-to-front LRU cache.
//
// Usage:
//   A transaction is accepted at the rising edge where start is high and
//   busy is low; mode, key and handle are sampled there. mode = lookup
//   searches for key; mode = fill writes handle into the front slot if it is valid.
//   Each transaction returns exactly one result: done is high for one
//   cycle and hit, found_handle, evicted, evicted_handle and evicted_key
//   are valid in that cycle only. The receiver cannot stall.
// Timing:
//   Accept edge: every slot compares its key with the input key.
//   Next cycle (busy high): the match chain runs down the row of cells,
//   slots move back, and the result is registered.
//   done is high the cycle after that.
//   A new start is not taken while busy is high; the next start can be taken in the
//   same cycle that done is shown. The compare register in each cell followed
//   by the ripple through ENTRIES cells is why busy is raised after acceptance.
// Reset:
//   rst_n clears all slots (cache empty), busy and done.
module lru_move_to_front_cache_core #(
    parameter int ENTRIES = lmfc_pkg::ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           mode,
    input  logic [lmfc_pkg::KEY_W-1:0]     key,
    input  logic [lmfc_pkg::HANDLE_W-1:0]  handle,
    output logic                           done,
    output logic                           hit,
    output logic [lmfc_pkg::HANDLE_W-1:0]  found_handle,
    output logic                           evicted,
    output logic [lmfc_pkg::HANDLE_W-1:0]  evicted_handle,
    output logic [lmfc_pkg::KEY_W-1:0]     evicted_key
);
    import lmfc_pkg::*;

    logic                busy_reg;
    logic                busy_next;
    logic                op_mode_reg;
    logic [KEY_W-1:0]    op_key_reg;
    logic [HANDLE_W-1:0] op_handle_reg;

    logic                done_reg;
    logic                done_next;
    logic                hit_reg;
    logic                hit_next;
    logic [HANDLE_W-1:0] found_reg;
    logic [HANDLE_W-1:0] found_next;
    logic                ev_reg;
    logic                ev_next;
    logic [HANDLE_W-1:0] ev_handle_reg;
    logic [HANDLE_W-1:0] ev_handle_next;
    logic [KEY_W-1:0]    ev_key_reg;
    logic [KEY_W-1:0]    ev_key_next;

    logic                accept;
    logic                upd_lookup;
    logic                upd_fill;

    slot_t               slots [ENTRIES];
    slot_t               front_in;
    cell_ctrl_t          ctrl  [ENTRIES];
    logic                before_chain [ENTRIES+1];
    logic [HANDLE_W-1:0] acc_chain    [ENTRIES+1];
    logic                chain_hit;
    slot_t               last_slot;

    assign accept     = start && !busy_reg;
    assign upd_lookup = busy_reg && (op_mode_reg == MODE_LOOKUP);
    assign upd_fill   = busy_reg && (op_mode_reg == MODE_FILL);

    assign before_chain[0] = 1'b0;
    assign acc_chain[0]    = '0;
    assign chain_hit       = before_chain[ENTRIES];
    assign last_slot       = slots[ENTRIES-1];

    // Front cell takes the looked-up key (with its old handle on a hit),
    // or keeps its key and takes the new handle on a fill.
    always_comb
    begin
        if (op_mode_reg == MODE_FILL)
        begin
            front_in.valid  = slots[0].valid;
            front_in.key    = slots[0].key;
            front_in.handle = op_handle_reg;
        end
        else
        begin
            front_in.valid  = 1'b1;
            front_in.key    = op_key_reg;
            front_in.handle = acc_chain[ENTRIES];  // zero on a miss
        end
    end

    generate
        for (genvar s = 0; s < ENTRIES; s++)
        begin : g_cell
            slot_t prev_slot;

            if (s == 0)
            begin : g_front
                assign prev_slot     = front_in;
                // fill into an empty front slot is ignored
                assign ctrl[s].shift = upd_lookup || (upd_fill && slots[0].valid);
            end
            else
            begin : g_rest
                assign prev_slot     = slots[s-1];
                assign ctrl[s].shift = upd_lookup;
            end
            assign ctrl[s].capture = accept;

            lmfc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl[s]),
                .in_key     (key),
                .prev       (prev_slot),
                .before_in  (before_chain[s]),
                .acc_in     (acc_chain[s]),
                .slot       (slots[s]),
                .before_out (before_chain[s+1]),
                .acc_out    (acc_chain[s+1])
            );
        end
    endgenerate

    always_comb
    begin
        busy_next      = busy_reg;
        done_next      = 1'b0;
        hit_next       = hit_reg;
        found_next     = found_reg;
        ev_next        = ev_reg;
        ev_handle_next = ev_handle_reg;
        ev_key_next    = ev_key_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (busy_reg)
        begin
            busy_next      = 1'b0;
            done_next      = 1'b1;
            hit_next       = upd_lookup && chain_hit;
            found_next     = upd_lookup ? acc_chain[ENTRIES] : '0;
            // a miss drops the last slot; report it only if it held a handle
            ev_next        = upd_lookup && !chain_hit && last_slot.valid
                             && (last_slot.handle != '0);
            ev_handle_next = ev_next ? last_slot.handle : '0;
            ev_key_next    = ev_next ? last_slot.key : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            op_mode_reg   <= MODE_LOOKUP;
            op_key_reg    <= '0;
            op_handle_reg <= '0;
            hit_reg       <= 1'b0;
            found_reg     <= '0;
            ev_reg        <= 1'b0;
            ev_handle_reg <= '0;
            ev_key_reg    <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            done_reg      <= done_next;
            if (accept)
            begin
                op_mode_reg   <= mode;
                op_key_reg    <= key;
                op_handle_reg <= handle;
            end
            hit_reg       <= hit_next;
            found_reg     <= found_next;
            ev_reg        <= ev_next;
            ev_handle_reg <= ev_handle_next;
            ev_key_reg    <= ev_key_next;
        end
    end

    assign busy           = busy_reg;
    assign done           = done_reg;
    assign hit            = hit_reg;
    assign found_handle   = found_reg;
    assign evicted        = ev_reg;
    assign evicted_handle = ev_handle_reg;
    assign evicted_key    = ev_key_reg;

    // every accepted transaction finishes in the cycle after busy
    a_busy_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> done_reg)
        else $error("busy cycle not followed by done");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done while still busy");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && hit_reg |-> !ev_reg)
        else $error("hit and eviction in one transaction");

    a_miss_zero_handle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !hit_reg |-> found_reg == '0)
        else $error("nonzero handle without a hit");

    a_front_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (op_mode_reg == MODE_LOOKUP) |-> slots[0].valid)
        else $error("front slot invalid after lookup");

endmodule

>>> rtl/lmfc_cell.sv
// One cache slot: key compare, match/handle chain link and move-back register.
module lmfc_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lmfc_pkg::cell_ctrl_t           ctrl,
    input  logic [lmfc_pkg::KEY_W-1:0]     in_key,
    input  lmfc_pkg::slot_t                prev,
    input  logic                           before_in,
    input  logic [lmfc_pkg::HANDLE_W-1:0]  acc_in,
    output lmfc_pkg::slot_t                slot,
    output logic                           before_out,
    output logic [lmfc_pkg::HANDLE_W-1:0]  acc_out
);
    import lmfc_pkg::*;

    slot_t slot_reg;
    slot_t slot_next;
    logic  match_reg;
    logic  match_next;
    logic  first;

    // frontmost match: this slot matched and nothing ahead did
    assign first      = match_reg & ~before_in;
    assign before_out = before_in | match_reg;
    assign acc_out    = first ? slot_reg.handle : acc_in;

    always_comb
    begin
        slot_next  = slot_reg;
        match_next = match_reg;
        if (ctrl.capture)
        begin
            match_next = slot_reg.valid && (slot_reg.key == in_key);
        end
        if (ctrl.shift && !before_in)
        begin
            slot_next = prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            match_reg <= match_next;
        end
    end

    assign slot = slot_reg;

endmodule
